// File: src/bpa_pkg.sv
// Shared constants, types and helper functions of the buddy page allocator.
`default_nettype none
package bpa_pkg;

  localparam int unsigned TOP_ORDER   = 10;
  localparam int unsigned NUM_ORDERS  = TOP_ORDER + 1;
  localparam int unsigned PAGE_BITS   = 12;
  localparam int unsigned ADDR_BITS   = 32;
  localparam int unsigned PN_W        = ADDR_BITS - PAGE_BITS;
  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned ORD_W       = $clog2(NUM_ORDERS);
  localparam int unsigned RAM_DEPTH   = NUM_ORDERS * STACK_DEPTH;
  localparam int unsigned RAM_AW      = ORD_W + IDX_W;
  localparam int unsigned BYTES_W     = 33;
  localparam int unsigned KB_W        = 23;
  localparam int unsigned PAGES_W     = PN_W + 1;

  localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_SPAN  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_BLOCK = 2'd1,
    ST_IGNORED  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic [ADDR_BITS-1:0] alloc_addr;
    status_e              status;
    logic [KB_W-1:0]      free_kb;
    logic [KB_W-1:0]      total_kb;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] waddr;
    logic [PN_W-1:0]   wdata;
    logic [RAM_AW-1:0] raddr;
  } ram_req_t;

  function automatic logic [BYTES_W-1:0] blk_bytes(input logic [ORD_W-1:0] ord);
    blk_bytes = (BYTES_W'(1) << ord) << PAGE_BITS;
  endfunction

  function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
                                                 input logic [BYTES_W-1:0] b);
    logic [BYTES_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[BYTES_W] ? BYTES_MAX : s[BYTES_W-1:0];
  endfunction

  function automatic logic [BYTES_W-1:0] sat_sub(input logic [BYTES_W-1:0] a,
                                                 input logic [BYTES_W-1:0] b);
    sat_sub = (b > a) ? '0 : a - b;
  endfunction

endpackage
`default_nettype wire

// File: src/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: src/bpa_ctl.sv
// Allocator sequencer: order search, stack pops/pushes, buddy search and compaction.
`default_nettype none
module bpa_ctl import bpa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  op_e                  op_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  input  logic [ADDR_BITS-1:0] size_i,
  input  logic [ADDR_BITS-1:0] end_i,
  output logic                 idle_o,
  output logic                 res_valid_o,
  input  logic                 res_take_i,
  output res_t                 res_o,
  output ram_req_t             ram_o,
  input  logic [PN_W-1:0]      rdata_i
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_ORD   = 14'b00000000000010,
    S_ASRCH = 14'b00000000000100,
    S_AWAIT = 14'b00000000001000,
    S_SPLIT = 14'b00000000010000,
    S_FLVL  = 14'b00000000100000,
    S_FRD   = 14'b00000001000000,
    S_FCMP  = 14'b00000010000000,
    S_MVRD  = 14'b00000100000000,
    S_MVWR  = 14'b00001000000000,
    S_PUSH  = 14'b00010000000000,
    S_SORD  = 14'b00100000000000,
    S_SPUSH = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_e;

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  status_e              status_q, status_d;
  logic [ORD_W-1:0]     ord_q, ord_d, want_q, want_d;
  logic [PAGES_W-1:0]   pages_q, pages_d, cur_q, cur_d;
  logic [PN_W-1:0]      last_q, last_d, pn_q, pn_d;
  logic [CNT_W-1:0]     jn_q, jn_d, mv_q, mv_d;
  logic [CNT_W-1:0]     cnt_q [NUM_ORDERS];
  logic [CNT_W-1:0]     cnt_d [NUM_ORDERS];
  logic [BYTES_W-1:0]   free_q, free_d, man_q, man_d;
  logic [ADDR_BITS-1:0] res_addr_q, res_addr_d;

  logic [CNT_W-1:0]     cnt_sel, cnt_dec, mv_inc;
  logic [ORD_W-1:0]     ord_dec;
  logic [PN_W-1:0]      ord_bit, bud;
  logic [PAGES_W-1:0]   rem;
  logic [ADDR_BITS:0]   addr_up, size_up;
  logic                 has_room;

  assign cnt_sel  = cnt_q[ord_q];
  assign cnt_dec  = cnt_sel - CNT_W'(1);
  assign mv_inc   = mv_q + CNT_W'(1);
  assign ord_dec  = ord_q - ORD_W'(1);
  assign ord_bit  = PN_W'(1) << ord_q;
  assign bud      = pn_q ^ ord_bit;
  assign rem      = {1'b0, last_q} - cur_q;
  assign addr_up  = {1'b0, addr_i} + (ADDR_BITS+1)'((1 << PAGE_BITS) - 1);
  assign size_up  = {1'b0, size_i} + (ADDR_BITS+1)'((1 << PAGE_BITS) - 1);
  assign has_room = cnt_sel < CNT_W'(STACK_DEPTH);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    status_d   = status_q;
    ord_d      = ord_q;
    want_d     = want_q;
    pages_d    = pages_q;
    cur_d      = cur_q;
    last_d     = last_q;
    pn_d       = pn_q;
    jn_d       = jn_q;
    mv_d       = mv_q;
    cnt_d      = cnt_q;
    free_d     = free_q;
    man_d      = man_q;
    res_addr_d = res_addr_q;
    ram_o      = '0;
    ram_o.raddr = {ord_q, cnt_dec[IDX_W-1:0]};

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d       = op_i;
          status_d   = ST_OK;
          res_addr_d = '0;
          ord_d      = '0;
          pages_d    = size_up[ADDR_BITS:PAGE_BITS];
          pn_d       = addr_i[ADDR_BITS-1:PAGE_BITS];
          cur_d      = addr_up[ADDR_BITS:PAGE_BITS];
          last_d     = end_i[ADDR_BITS-1:PAGE_BITS];
          case (op_i)
            OP_ALLOC: begin
              if (size_i == '0) begin
                status_d = ST_IGNORED;
                state_d  = S_DONE;
              end else begin
                state_d = S_ORD;
              end
            end
            OP_FREE: begin
              if (size_i == '0 || addr_i == '0) begin
                status_d = ST_IGNORED;
                state_d  = S_DONE;
              end else begin
                state_d = S_ORD;
              end
            end
            OP_SPAN: state_d = S_SORD;
            default: begin
              status_d = ST_IGNORED;
              state_d  = S_DONE;
            end
          endcase
        end
      end
      // one order step per cycle until the block covers the pages
      S_ORD: begin
        if (pages_q <= (PAGES_W'(1) << ord_q)) begin
          want_d = ord_q;
          if (op_q == OP_ALLOC) begin
            status_d = ST_NO_BLOCK;
            state_d  = S_ASRCH;
          end else begin
            state_d = S_FLVL;
          end
        end else if (ord_q == ORD_W'(TOP_ORDER)) begin
          status_d = ST_IGNORED;
          state_d  = S_DONE;
        end else begin
          ord_d = ord_q + ORD_W'(1);
        end
      end
      S_ASRCH: begin
        if (cnt_sel != '0) begin
          cnt_d[ord_q] = cnt_dec;
          free_d       = sat_sub(free_q, blk_bytes(ord_q));
          state_d      = S_AWAIT;
        end else if (ord_q == ORD_W'(TOP_ORDER)) begin
          state_d = S_DONE;
        end else begin
          ord_d = ord_q + ORD_W'(1);
        end
      end
      S_AWAIT: begin
        pn_d    = rdata_i;
        state_d = S_SPLIT;
      end
      S_SPLIT: begin
        if (ord_q > want_q) begin
          ord_d = ord_dec;
          if (cnt_q[ord_dec] < CNT_W'(STACK_DEPTH)) begin
            ram_o.we     = 1'b1;
            ram_o.waddr  = {ord_dec, cnt_q[ord_dec][IDX_W-1:0]};
            ram_o.wdata  = pn_q + (PN_W'(1) << ord_dec);
            cnt_d[ord_dec] = cnt_q[ord_dec] + CNT_W'(1);
            free_d       = sat_add(free_q, blk_bytes(ord_dec));
          end
        end else begin
          res_addr_d = ADDR_BITS'({pn_q, {PAGE_BITS{1'b0}}});
          status_d   = ST_OK;
          state_d    = S_DONE;
        end
      end
      S_FLVL: begin
        if (ord_q == ORD_W'(TOP_ORDER)) begin
          state_d = S_PUSH;
        end else begin
          jn_d    = cnt_sel;
          state_d = S_FRD;
        end
      end
      // scan the stack from the top, one entry per read/compare pair
      S_FRD: begin
        ram_o.raddr = {ord_q, jn_q[IDX_W-1:0] - IDX_W'(1)};
        if (jn_q == '0) begin
          state_d = S_PUSH;
        end else begin
          jn_d    = jn_q - CNT_W'(1);
          state_d = S_FCMP;
        end
      end
      S_FCMP: begin
        if (rdata_i == bud) begin
          mv_d    = jn_q;
          state_d = S_MVRD;
        end else begin
          state_d = S_FRD;
        end
      end
      // close the gap left by the taken buddy
      S_MVRD: begin
        ram_o.raddr = {ord_q, mv_inc[IDX_W-1:0]};
        if (mv_inc < cnt_sel) begin
          state_d = S_MVWR;
        end else begin
          cnt_d[ord_q] = cnt_dec;
          free_d       = sat_sub(free_q, blk_bytes(ord_q));
          pn_d         = pn_q & ~ord_bit;
          ord_d        = ord_q + ORD_W'(1);
          state_d      = S_FLVL;
        end
      end
      S_MVWR: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = {ord_q, mv_q[IDX_W-1:0]};
        ram_o.wdata = rdata_i;
        mv_d        = mv_inc;
        state_d     = S_MVRD;
      end
      S_PUSH: begin
        if (has_room) begin
          ram_o.we     = 1'b1;
          ram_o.waddr  = {ord_q, cnt_sel[IDX_W-1:0]};
          ram_o.wdata  = pn_q;
          cnt_d[ord_q] = cnt_sel + CNT_W'(1);
          free_d       = sat_add(free_q, blk_bytes(ord_q));
        end else begin
          status_d = ST_OVERFLOW;
        end
        state_d = S_DONE;
      end
      // grow the block while aligned and inside the remaining span
      S_SORD: begin
        if ({1'b0, last_q} <= cur_q) begin
          state_d = S_DONE;
        end else if (ord_q < ORD_W'(TOP_ORDER) && !cur_q[ord_q] &&
                     ((rem >> ord_q) >> 1) != '0) begin
          ord_d = ord_q + ORD_W'(1);
        end else begin
          state_d = S_SPUSH;
        end
      end
      S_SPUSH: begin
        if (has_room) begin
          ram_o.we     = 1'b1;
          ram_o.waddr  = {ord_q, cnt_sel[IDX_W-1:0]};
          ram_o.wdata  = cur_q[PN_W-1:0];
          cnt_d[ord_q] = cnt_sel + CNT_W'(1);
          free_d       = sat_add(free_q, blk_bytes(ord_q));
          man_d        = sat_add(man_q, blk_bytes(ord_q));
          cur_d        = cur_q + (PAGES_W'(1) << ord_q);
          ord_d        = '0;
          state_d      = S_SORD;
        end else begin
          status_d = ST_OVERFLOW;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ord_q   <= '0;
      cnt_q   <= '{default: '0};
      free_q  <= '0;
      man_q   <= '0;
    end else begin
      state_q <= state_d;
      ord_q   <= ord_d;
      cnt_q   <= cnt_d;
      free_q  <= free_d;
      man_q   <= man_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    status_q   <= status_d;
    want_q     <= want_d;
    pages_q    <= pages_d;
    cur_q      <= cur_d;
    last_q     <= last_d;
    pn_q       <= pn_d;
    jn_q       <= jn_d;
    mv_q       <= mv_d;
    res_addr_q <= res_addr_d;
  end

  assign idle_o           = (state_q == S_IDLE);
  assign res_valid_o      = (state_q == S_DONE);
  assign res_o.alloc_addr = res_addr_q;
  assign res_o.status     = status_q;
  assign res_o.free_kb    = free_q[BYTES_W-1:10];
  assign res_o.total_kb   = man_q[BYTES_W-1:10];

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_sel <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");
  a_split_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SPLIT) |-> (ord_q >= want_q))
    else $error("split below requested order");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && idle_o) |=> !idle_o)
    else $error("sequencer idle after start");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !ram_o.we)
    else $error("stack write outside an operation");
`endif

endmodule
`default_nettype wire

// File: src/buddy_page_allocator.sv
// Top level of the buddy page allocator: input handshake, stack RAM, result register.
`default_nettype none
// Buddy page allocator. Each accepted beat is one operation (alloc, free, or
// add span) and yields exactly one result beat carrying the allocated address,
// a status code and the free/managed kilobyte counts after the operation.
// One operation is processed at a time by a sequencer; in_ready_o is high only
// while it is idle. Latency is data-dependent: alloc steps up to the requested
// order w, searches upward for a non-empty stack at order f, then splits from f
// down to w; free scans stack entries from the top and, after a buddy is taken,
// shifts the entries above it down to close the gap, once per merge level, for
// up to ten levels; add span carves the span into aligned blocks and pushes
// them one at a time. Every step
// is bounded by the single port pair of the free-stack RAM (11 orders x 1024
// page numbers of 20 bits, registered read). Stack memory needs no clearing
// after reset: per-order counts are reset and only entries below the count are
// ever read. A finished result sits in an output register, so the next beat
// can be accepted while it waits.
module buddy_page_allocator import bpa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           op_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  input  logic [31:0]          size_bytes_i,
  input  logic [ADDR_BITS-1:0] span_end_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          alloc_addr_o,
  output logic [1:0]           status_o,
  output logic [KB_W-1:0]      free_kb_o,
  output logic [KB_W-1:0]      total_kb_o
);

  logic             idle;
  logic             res_valid;
  logic             res_take;
  res_t             res;
  res_t             out_q;
  logic             out_valid_q;
  ram_req_t         ram_req;
  logic [PN_W-1:0]  ram_rdata;

  assign in_ready_o = idle;

  // result register frees up when empty or when downstream takes the beat
  assign res_take = !out_valid_q || out_ready_i;

  bpa_ctl u_ctl (
    .clk_i,
    .rst_ni,
    .start_i     (in_valid_i && idle),
    .op_i        (op_e'(op_i)),
    .addr_i,
    .size_i      (size_bytes_i),
    .end_i       (span_end_i),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .ram_o       (ram_req),
    .rdata_i     (ram_rdata)
  );

  bpa_ram #(
    .WIDTH (PN_W),
    .DEPTH (RAM_DEPTH)
  ) u_stack_ram (
    .clk_i,
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign alloc_addr_o = out_q.alloc_addr;
  assign status_o     = out_q.status;
  assign free_kb_o    = out_q.free_kb;
  assign total_kb_o   = out_q.total_kb;

endmodule
`default_nettype wire
